@@ hw/rtl/plf_pkg.sv @@
// plf_pkg: shared types, constants and helpers for the Playfair digraph cipher.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package plf_pkg;

   localparam int SQ_DIM   = 5;
   localparam int SQ_CELLS = 25;
   localparam int CODE_W   = 5;
   localparam int POS_W    = 3;
   localparam int CSR_W    = 50;
   localparam int CSR_IDX_W = 2;

   localparam logic [CODE_W-1:0] CODE_I = 5'd8;
   localparam logic [CODE_W-1:0] CODE_J = 5'd9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_FIRST  = 2'd0,
      CSR_ROWS_MIDDLE = 2'd1,
      CSR_ROW_FINAL   = 2'd2,
      CSR_DIRECTION   = 2'd3
   } csr_index_type;

   typedef logic [SQ_CELLS-1:0][CODE_W-1:0] square_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } loc_type;

   typedef struct packed {
      logic [CODE_W-1:0] first;
      logic [CODE_W-1:0] second;
      logic              missing;
   } result_type;

   // one step along a row or column, with wrap
   function automatic logic [POS_W-1:0] step5(input logic [POS_W-1:0] v, input logic back);
      logic [POS_W-1:0] r;
      if (back) begin
         r = (v == '0) ? POS_W'(SQ_DIM - 1) : v - POS_W'(1);
      end else begin
         r = (v == POS_W'(SQ_DIM - 1)) ? '0 : v + POS_W'(1);
      end
      return r;
   endfunction

   // row * 5 + col
   function automatic logic [CODE_W-1:0] cell_index(input logic [POS_W-1:0] r,
                                                    input logic [POS_W-1:0] c);
      return CODE_W'({r, 2'b00}) + CODE_W'(r) + CODE_W'(c);
   endfunction

endpackage

@@ hw/rtl/plf_lane.sv @@
// plf_lane: locates one letter in the key square (highest matching entry wins).
// Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_lane (
   input  logic [plf_pkg::CODE_W-1:0] letter,
   input  plf_pkg::square_type        square,
   output plf_pkg::loc_type           loc
);

   logic [plf_pkg::CODE_W-1:0] key;

   assign key = (letter == plf_pkg::CODE_J) ? plf_pkg::CODE_I : letter;

   always_comb begin
      loc = '0;
      for (int k = 0; k < plf_pkg::SQ_CELLS; k++) begin
         if (square[k] == key) begin
            loc.found = 1'b1;
            loc.row   = plf_pkg::POS_W'(k / plf_pkg::SQ_DIM);
            loc.col   = plf_pkg::POS_W'(k % plf_pkg::SQ_DIM);
         end
      end
   end

endmodule

@@ hw/rtl/plf_merge.sv @@
// plf_merge: combines the two lane positions into the output pair.
// Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_merge (
   input  plf_pkg::loc_type    loc_a,
   input  plf_pkg::loc_type    loc_b,
   input  plf_pkg::square_type square,
   input  logic                back,
   output plf_pkg::result_type result
);

   logic [plf_pkg::CODE_W-1:0] idx_a;
   logic [plf_pkg::CODE_W-1:0] idx_b;

   always_comb begin
      if (loc_a.row == loc_b.row) begin
         idx_a = plf_pkg::cell_index(loc_a.row, plf_pkg::step5(loc_a.col, back));
         idx_b = plf_pkg::cell_index(loc_b.row, plf_pkg::step5(loc_b.col, back));
      end else if (loc_a.col == loc_b.col) begin
         idx_a = plf_pkg::cell_index(plf_pkg::step5(loc_a.row, back), loc_a.col);
         idx_b = plf_pkg::cell_index(plf_pkg::step5(loc_b.row, back), loc_b.col);
      end else begin
         idx_a = plf_pkg::cell_index(loc_a.row, loc_b.col);
         idx_b = plf_pkg::cell_index(loc_b.row, loc_a.col);
      end
   end

   always_comb begin
      if (loc_a.found && loc_b.found) begin
         result.first   = square[idx_a];
         result.second  = square[idx_b];
         result.missing = 1'b0;
      end else begin
         result.first   = '0;
         result.second  = '0;
         result.missing = 1'b1;
      end
   end

endmodule

@@ hw/rtl/playfair_digraph_cipher.sv @@
// playfair_digraph_cipher: top level, config registers and two-stage pipeline.
// Depends on plf_pkg, plf_lane, plf_merge.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   letter_first, letter_second, pair_is_last
//   rsp      out        rsp_valid/rsp_stall   out_first, out_second, out_is_last,
//                                             letter_missing
//   csr      in         csr_wr_en             csr_index, csr_wdata
//
// One item per cycle while rsp is not stalled (lane search stage, merge stage into
// the output register). Reset clears config registers and empties the pipeline.
// A stall on rsp holds the output item; req stalls only when both stages are full.
`timescale 1ns / 1ps

module playfair_digraph_cipher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [plf_pkg::CODE_W-1:0]    req_letter_first,
   input  logic [plf_pkg::CODE_W-1:0]    req_letter_second,
   input  logic                          req_pair_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [plf_pkg::CODE_W-1:0]    rsp_out_first,
   output logic [plf_pkg::CODE_W-1:0]    rsp_out_second,
   output logic                          rsp_out_is_last,
   output logic                          rsp_letter_missing,
   input  logic                          csr_wr_en,
   input  logic [plf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [plf_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int HalfW = 10 * plf_pkg::CODE_W;
   localparam int FinalW = 5 * plf_pkg::CODE_W;

   logic [HalfW-1:0]  rows_first_ff;
   logic [HalfW-1:0]  rows_middle_ff;
   logic [FinalW-1:0] row_final_ff;
   logic              direction_ff;
   plf_pkg::square_type square;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_first_ff  <= '0;
         rows_middle_ff <= '0;
         row_final_ff   <= '0;
         direction_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         case (plf_pkg::csr_index_type'(csr_index))
            plf_pkg::CSR_ROWS_FIRST:  rows_first_ff  <= csr_wdata[HalfW-1:0];
            plf_pkg::CSR_ROWS_MIDDLE: rows_middle_ff <= csr_wdata[HalfW-1:0];
            plf_pkg::CSR_ROW_FINAL:   row_final_ff   <= csr_wdata[FinalW-1:0];
            plf_pkg::CSR_DIRECTION:   direction_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign square = {row_final_ff, rows_middle_ff, rows_first_ff};

   // lanes
   plf_pkg::loc_type loc_a;
   plf_pkg::loc_type loc_b;

   plf_lane u_lane_a (.letter(req_letter_first),  .square(square), .loc(loc_a));
   plf_lane u_lane_b (.letter(req_letter_second), .square(square), .loc(loc_b));

   // stage 1
   logic             s1_valid_ff;
   plf_pkg::loc_type s1_loc_a_ff;
   plf_pkg::loc_type s1_loc_b_ff;
   logic             s1_last_ff;
   logic             s2_ready;
   logic             s1_ready;

   assign s2_ready  = !rsp_valid || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_loc_a_ff <= loc_a;
         s1_loc_b_ff <= loc_b;
         s1_last_ff  <= req_pair_is_last;
      end
   end

   // merge and output register
   plf_pkg::result_type result;

   plf_merge u_merge (
      .loc_a(s1_loc_a_ff),
      .loc_b(s1_loc_b_ff),
      .square(square),
      .back(direction_ff),
      .result(result)
   );

   logic                rsp_valid_ff;
   plf_pkg::result_type rsp_result_ff;
   logic                rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         rsp_result_ff <= result;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_first      = rsp_result_ff.first;
   assign rsp_out_second     = rsp_result_ff.second;
   assign rsp_out_is_last    = rsp_last_ff;
   assign rsp_letter_missing = rsp_result_ff.missing;

endmodule

@@ hw/rtl/plf_checker.sv @@
// plf_checker: port-level assertions for playfair_digraph_cipher, bound to the top.
// Depends on plf_pkg and playfair_digraph_cipher.
`timescale 1ns / 1ps

module plf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [plf_pkg::CODE_W-1:0]    rsp_out_first,
   input logic [plf_pkg::CODE_W-1:0]    rsp_out_second,
   input logic                          rsp_out_is_last,
   input logic                          rsp_letter_missing
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_first)
         && $stable(rsp_out_second) && $stable(rsp_out_is_last)
         && $stable(rsp_letter_missing))
      else $error("stalled rsp item changed");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_letter_missing |-> rsp_out_first == '0 && rsp_out_second == '0)
      else $error("missing letter with nonzero outputs");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a stalled output");

endmodule

bind playfair_digraph_cipher plf_checker u_plf_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_out_first(rsp_out_first),
   .rsp_out_second(rsp_out_second),
   .rsp_out_is_last(rsp_out_is_last),
   .rsp_letter_missing(rsp_letter_missing)
);
